// File: rtl/core/ccd_ik_arm_step_unit_macros.svh
// Assertion macros for the CCD arm step unit.
// Used by ccd_ik_arm_step_unit.sv; no other dependencies.
`ifndef CCD_IK_ARM_STEP_UNIT_MACROS_SVH
`define CCD_IK_ARM_STEP_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CCD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ccd_pkg.sv
// Shared types and constants of the CCD arm step unit.
// No dependencies.
package ccd_pkg;

  localparam int PW     = 28;       // internal position width, Q.8
  localparam int DW     = PW + 1;   // coordinate difference width
  localparam int CW     = 34;       // CORDIC x/y/z width
  localparam int ITERS  = 16;       // CORDIC rotations
  localparam int CIDX_W = 3;        // config index width
  localparam int CDAT_W = 48;       // config data width
  localparam int JIDX_W = 4;        // joint index width on ports and commands

  localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

  localparam logic [CIDX_W-1:0] CFG_BASE_X    = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_BASE_Y    = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_SEG_LEN   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_TIP_EXT   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_MAX_STEP  = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_PASS_CNT  = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_NEAR_DSQ  = 3'd6;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_PASS,
    OP_SC_LOAD,
    OP_SC_ITER,
    OP_MUL,
    OP_ACC,
    OP_AT_LOAD,
    OP_AT_NORM,
    OP_AT_ITER,
    OP_AT_SAVE,
    OP_UPD,
    OP_SQ,
    OP_NEAR
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PASS,
    ST_SC_LOAD,
    ST_SC_ROT,
    ST_MUL,
    ST_ACC,
    ST_CHK,
    ST_AT_LOAD,
    ST_AT_NORM,
    ST_AT_ROT,
    ST_AT_END,
    ST_SQ,
    ST_NEAR,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e              op;
    logic [JIDX_W-1:0]   jnt;
    logic [3:0]          itr;
    logic                sel_tgt;
  } ccd_cmd_t;

  typedef struct packed {
    logic       norm_done;
    logic       degen;
    logic [3:0] passes;
  } ccd_stat_t;

  // atan(2^-i) in 32-bit turn units
  function automatic logic [31:0] atan_lut(input logic [3:0] i);
    logic [31:0] r;
    case (i)
      4'd0:    r = 32'h20000000;
      4'd1:    r = 32'h12E4051E;
      4'd2:    r = 32'h09FB385B;
      4'd3:    r = 32'h051111D4;
      4'd4:    r = 32'h028B0D43;
      4'd5:    r = 32'h0145D7E1;
      4'd6:    r = 32'h00A2F61E;
      4'd7:    r = 32'h00517C55;
      4'd8:    r = 32'h0028BE53;
      4'd9:    r = 32'h00145F2F;
      4'd10:   r = 32'h000A2F98;
      4'd11:   r = 32'h000517CC;
      4'd12:   r = 32'h00028BE6;
      4'd13:   r = 32'h000145F3;
      4'd14:   r = 32'h0000A2F9;
      default: r = 32'h0000517D;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/ccd_ctrl.sv
// Sequencer of the CCD arm step unit: passes, joints, CORDIC steps, result drain.
// Depends on ccd_pkg.
module ccd_ctrl import ccd_pkg::*; #(
  parameter int NUM_JOINTS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output logic      is_last_o,
  input  ccd_stat_t stat_i,
  output ccd_cmd_t  cmd_o
);

  localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam logic [JW-1:0] J_LAST = JW'(NUM_JOINTS - 1);

  ctrl_state_e   state_q, state_d;
  logic [JW-1:0] jnt_q, jnt_d;
  logic [3:0]    itr_q, itr_d;
  logic [3:0]    pass_q, pass_d;
  logic          sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      jnt_q   <= '0;
      itr_q   <= '0;
      pass_q  <= '0;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      jnt_q   <= jnt_d;
      itr_q   <= itr_d;
      pass_q  <= pass_d;
      sel_q   <= sel_d;
    end
  end

  // next state and counters
  always_comb begin
    state_d = state_q;
    jnt_d   = jnt_q;
    itr_d   = itr_q;
    pass_d  = pass_q;
    sel_d   = sel_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          pass_d  = '0;
          state_d = ST_PASS;
        end
      end
      ST_PASS: begin
        jnt_d   = '0;
        state_d = ST_SC_LOAD;
      end
      ST_SC_LOAD: begin
        itr_d   = '0;
        state_d = ST_SC_ROT;
      end
      ST_SC_ROT: begin
        itr_d = itr_q + 4'd1;
        if (itr_q == 4'(ITERS - 1)) state_d = ST_MUL;
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: begin
        if (jnt_q == J_LAST) begin
          jnt_d   = '0;
          state_d = ST_CHK;
        end else begin
          jnt_d   = jnt_q + 1'b1;
          state_d = ST_SC_LOAD;
        end
      end
      ST_CHK, ST_AT_END: begin
        if ((state_q == ST_CHK && !stat_i.degen) || (state_q == ST_AT_END && !sel_q)) begin
          sel_d   = (state_q == ST_AT_END);
          state_d = ST_AT_LOAD;
        end else if (jnt_q != J_LAST) begin
          jnt_d   = jnt_q + 1'b1;
          state_d = ST_CHK;
        end else if (pass_q == stat_i.passes - 4'd1) begin
          state_d = ST_SQ;
        end else begin
          pass_d  = pass_q + 4'd1;
          state_d = ST_PASS;
        end
      end
      ST_AT_LOAD: state_d = ST_AT_NORM;
      ST_AT_NORM: begin
        if (stat_i.norm_done) begin
          itr_d   = '0;
          state_d = ST_AT_ROT;
        end
      end
      ST_AT_ROT: begin
        itr_d = itr_q + 4'd1;
        if (itr_q == 4'(ITERS - 1)) state_d = ST_AT_END;
      end
      ST_SQ: state_d = ST_NEAR;
      ST_NEAR: begin
        jnt_d   = '0;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          if (jnt_q == J_LAST) state_d = ST_IDLE;
          else jnt_d = jnt_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands and handshakes
  always_comb begin
    cmd_o.op      = OP_NONE;
    cmd_o.jnt     = JIDX_W'(jnt_q);
    cmd_o.itr     = itr_q;
    cmd_o.sel_tgt = sel_q;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    is_last_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_START;
      end
      ST_PASS:    cmd_o.op = OP_PASS;
      ST_SC_LOAD: cmd_o.op = OP_SC_LOAD;
      ST_SC_ROT:  cmd_o.op = OP_SC_ITER;
      ST_MUL:     cmd_o.op = OP_MUL;
      ST_ACC:     cmd_o.op = OP_ACC;
      ST_AT_LOAD: cmd_o.op = OP_AT_LOAD;
      ST_AT_NORM: cmd_o.op = stat_i.norm_done ? OP_NONE : OP_AT_NORM;
      ST_AT_ROT:  cmd_o.op = OP_AT_ITER;
      ST_AT_END:  cmd_o.op = sel_q ? OP_UPD : OP_AT_SAVE;
      ST_SQ:      cmd_o.op = OP_SQ;
      ST_NEAR:    cmd_o.op = OP_NEAR;
      ST_OUT: begin
        out_valid_o = 1'b1;
        is_last_o   = (jnt_q == J_LAST);
      end
      default:    cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// File: rtl/core/ccd_dp.sv
// Datapath of the CCD arm step unit: config, joint state, shared CORDIC, multipliers.
// Depends on ccd_pkg.
module ccd_dp import ccd_pkg::*; #(
  parameter int NUM_JOINTS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CIDX_W-1:0]        cfg_idx_i,
  input  logic [CDAT_W-1:0]        cfg_data_i,
  input  logic signed [23:0]       target_x_i,
  input  logic signed [23:0]       target_y_i,
  input  ccd_cmd_t                 cmd_i,
  output ccd_stat_t                stat_o,
  output logic [15:0]              joint_angle_o,
  output logic signed [23:0]       tip_x_o,
  output logic signed [23:0]       tip_y_o,
  output logic                     near_target_o,
  output logic [15:0]              grip_phase_o
);

  localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam logic [JW-1:0] J_LAST = JW'(NUM_JOINTS - 1);
  localparam int MW = 54;  // trig * length product
  localparam int SW = 2 * DW;

  localparam logic signed [CW-1:0] Q_TURN = 34'sd1073741824;
  localparam logic signed [CW-1:0] H_TURN = 34'sd2147483648;
  localparam logic signed [CW-1:0] NORM_MIN = 34'sd268435456;  // 2^28
  localparam logic signed [CW-1:0] NORM_S4  = 34'sd33554432;   // 2^25
  localparam logic signed [CW-1:0] NORM_S8  = 34'sd2097152;    // 2^21
  localparam logic signed [PW-1:0] SAT_HI = 28'sd8388607;
  localparam logic signed [PW-1:0] SAT_LO = -28'sd8388608;

  // configuration
  logic signed [23:0] base_x_q, base_y_q;
  logic [19:0]        seg_q, ext_q;
  logic [14:0]        max_step_q;
  logic [3:0]         pass_cnt_q;
  logic [47:0]        near_dsq_q;

  // item state
  logic [15:0]          ang_q [NUM_JOINTS];
  logic [15:0]          phase_q;
  logic                 near_q;
  logic signed [PW-1:0] tgt_x_q, tgt_y_q, px_q, py_q;
  logic signed [PW-1:0] ox_q [NUM_JOINTS];
  logic signed [PW-1:0] oy_q [NUM_JOINTS];
  logic signed [CW-1:0] cx_q, cy_q, cz_q;
  logic                 neg_q;
  logic signed [MW-1:0] prc_q, prs_q;
  logic [15:0]          ae_q;
  logic [SW-1:0]        sqx_q, sqy_q;

  logic [JW-1:0] j;
  assign j = cmd_i.jnt[JW-1:0];

  // segment length and sincos fold
  logic [20:0]          len;
  logic signed [CW-1:0] za, za_f;
  logic                 za_neg;
  always_comb begin
    len = (j == J_LAST) ? ({1'b0, seg_q} + {1'b0, ext_q}) : {1'b0, seg_q};
    za  = CW'($signed({ang_q[j], 16'h0000}));
    za_f   = za;
    za_neg = 1'b0;
    if (za > Q_TURN) begin
      za_f   = za - H_TURN;
      za_neg = 1'b1;
    end else if (za < -Q_TURN) begin
      za_f   = za + H_TURN;
      za_neg = 1'b1;
    end
  end

  // CORDIC step terms
  logic signed [CW-1:0] xs, ys, at;
  assign xs = cx_q >>> cmd_i.itr;
  assign ys = cy_q >>> cmd_i.itr;
  assign at = CW'({2'b00, atan_lut(cmd_i.itr)});

  // atan2 vector load with fold to right half plane
  logic signed [DW-1:0] vx, vy;
  always_comb begin
    vx = cmd_i.sel_tgt ? (DW'(tgt_x_q) - DW'(ox_q[j])) : (DW'(px_q) - DW'(ox_q[j]));
    vy = cmd_i.sel_tgt ? (DW'(tgt_y_q) - DW'(oy_q[j])) : (DW'(py_q) - DW'(oy_q[j]));
  end

  // normalization magnitude (x is non-negative after the fold)
  logic signed [CW-1:0] ay, mag;
  assign ay  = cy_q[CW-1] ? -cy_q : cy_q;
  assign mag = (cx_q > ay) ? cx_q : ay;

  // angle rounding and joint update
  logic signed [CW-1:0] zr;
  logic [15:0]          ap, d16, ang_n;
  logic signed [16:0]   d17, lim;
  always_comb begin
    zr  = cz_q + 34'sd32768;
    ap  = zr[31:16];
    d16 = ap - ae_q;
    d17 = (d16 > 16'd32768) ? $signed({1'b1, d16}) : $signed({1'b0, d16});
    lim = $signed({2'b00, max_step_q});
    if (d17 > lim)       d17 = lim;
    else if (d17 < -lim) d17 = -lim;
    ang_n = ang_q[j] + d17[15:0];
  end

  // forward kinematics step rounding
  logic signed [CW-1:0] cs_x, cs_y;
  logic signed [MW-1:0] rc, rs;
  assign cs_x = neg_q ? -cx_q : cx_q;
  assign cs_y = neg_q ? -cy_q : cy_q;
  assign rc   = prc_q + (54'sd1 <<< 29);
  assign rs   = prs_q + (54'sd1 <<< 29);

  logic signed [DW-1:0] dx, dy;
  logic [SW:0]          dsq;
  assign dx  = DW'(px_q) - DW'(tgt_x_q);
  assign dy  = DW'(py_q) - DW'(tgt_y_q);
  assign dsq = {1'b0, sqx_q} + {1'b0, sqy_q};

  // control-visible state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_x_q   <= '0;
      base_y_q   <= '0;
      seg_q      <= 20'd10240;
      ext_q      <= 20'd5120;
      max_step_q <= 15'd522;
      pass_cnt_q <= 4'd10;
      near_dsq_q <= 48'd163840000;
      phase_q    <= '0;
      near_q     <= 1'b0;
      for (int k = 0; k < NUM_JOINTS; k++) ang_q[k] <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BASE_X:   base_x_q   <= cfg_data_i[23:0];
          CFG_BASE_Y:   base_y_q   <= cfg_data_i[23:0];
          CFG_SEG_LEN:  seg_q      <= cfg_data_i[19:0];
          CFG_TIP_EXT:  ext_q      <= cfg_data_i[19:0];
          CFG_MAX_STEP: max_step_q <= cfg_data_i[14:0];
          CFG_PASS_CNT: pass_cnt_q <= cfg_data_i[3:0];
          CFG_NEAR_DSQ: near_dsq_q <= cfg_data_i[47:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_UPD) ang_q[j] <= ang_n;
      if (cmd_i.op == OP_NEAR) begin
        near_q <= (dsq < (SW + 1)'(near_dsq_q));
        if (dsq < (SW + 1)'(near_dsq_q)) phase_q <= phase_q + 16'd1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_START: begin
        tgt_x_q <= PW'(target_x_i);
        tgt_y_q <= PW'(target_y_i);
      end
      OP_PASS: begin
        px_q <= PW'(base_x_q);
        py_q <= PW'(base_y_q);
      end
      OP_SC_LOAD: begin
        ox_q[j] <= px_q;
        oy_q[j] <= py_q;
        cx_q    <= CORDIC_K;
        cy_q    <= '0;
        cz_q    <= za_f;
        neg_q   <= za_neg;
      end
      OP_SC_ITER: begin
        if (!cz_q[CW-1]) begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - at;
        end else begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + at;
        end
      end
      OP_MUL: begin
        prc_q <= MW'($signed(cs_x[31:0]) * $signed({1'b0, len}));
        prs_q <= MW'($signed(cs_y[31:0]) * $signed({1'b0, len}));
      end
      OP_ACC: begin
        px_q <= px_q + PW'(rc >>> 30);
        py_q <= py_q + PW'(rs >>> 30);
      end
      OP_AT_LOAD: begin
        if (vx[DW-1]) begin
          cx_q <= -CW'(vx);
          cy_q <= -CW'(vy);
          cz_q <= H_TURN;
        end else begin
          cx_q <= CW'(vx);
          cy_q <= CW'(vy);
          cz_q <= '0;
        end
      end
      OP_AT_NORM: begin
        if (mag < NORM_S8) begin
          cx_q <= cx_q <<< 8;
          cy_q <= cy_q <<< 8;
        end else if (mag < NORM_S4) begin
          cx_q <= cx_q <<< 4;
          cy_q <= cy_q <<< 4;
        end else begin
          cx_q <= cx_q <<< 1;
          cy_q <= cy_q <<< 1;
        end
      end
      OP_AT_ITER: begin
        if (cy_q > 0) begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + at;
        end else begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - at;
        end
      end
      OP_AT_SAVE: ae_q <= ap;
      OP_SQ: begin
        sqx_q <= SW'(dx * dx);
        sqy_q <= SW'(dy * dy);
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.norm_done = (mag >= NORM_MIN);
    stat_o.degen     = (px_q == ox_q[j] && py_q == oy_q[j]) ||
                       (tgt_x_q == ox_q[j] && tgt_y_q == oy_q[j]);
    stat_o.passes    = (pass_cnt_q == 4'd0) ? 4'd1 : pass_cnt_q;
  end

  assign joint_angle_o = ang_q[j];
  assign near_target_o = near_q;
  assign grip_phase_o  = phase_q;
  assign tip_x_o = (px_q > SAT_HI) ? 24'sh7FFFFF : (px_q < SAT_LO) ? 24'sh800000 : px_q[23:0];
  assign tip_y_o = (py_q > SAT_HI) ? 24'sh7FFFFF : (py_q < SAT_LO) ? 24'sh800000 : py_q[23:0];

endmodule

// File: rtl/core/ccd_ik_arm_step_unit.sv
// Top level of the CCD inverse-kinematics arm step unit.
// Depends on ccd_pkg, ccd_ctrl, ccd_dp and ccd_ik_arm_step_unit_macros.svh.
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------
//  in      | in_valid_i/in_ready_o  | target_x_i, target_y_i
//  out     | out_valid_o/out_ready_i| joint_index_o, joint_angle_o, tip_x/y_o,
//          |                        | near_target_o, grip_phase_o, is_last_o
//  cfg     | cfg_we_i (no wait)     | cfg_idx_i, cfg_data_i
//
// One target at a time. Per pass: a setup step, then forward kinematics per
// joint (load, 16 sincos rotations, multiply, accumulate), then per joint a check
// step plus, unless the joint is degenerate, two atan2 runs of load, normalize,
// 16 rotations and end. After the last pass comes the distance test (square, compare)
// and one result per cycle while out_ready_i is high. The CORDIC is shared by all runs.
// Reset clears joint angles, phase and loads config defaults; no clearing pass.
// in_ready_o is high only while idle; output stalls simply hold the result.
`include "ccd_ik_arm_step_unit_macros.svh"

module ccd_ik_arm_step_unit import ccd_pkg::*; #(
  parameter int NUM_JOINTS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CIDX_W-1:0]   cfg_idx_i,
  input  logic [CDAT_W-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [23:0]  target_x_i,
  input  logic signed [23:0]  target_y_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [3:0]          joint_index_o,
  output logic [15:0]         joint_angle_o,
  output logic signed [23:0]  tip_x_o,
  output logic signed [23:0]  tip_y_o,
  output logic                near_target_o,
  output logic [15:0]         grip_phase_o,
  output logic                is_last_o
);

  localparam logic [3:0] IDX_LAST = 4'(NUM_JOINTS - 1);

  ccd_cmd_t  cmd;
  ccd_stat_t stat;

  // sequencer: owns pass, joint and rotation counters
  ccd_ctrl #(.NUM_JOINTS(NUM_JOINTS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .is_last_o   (is_last_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: config, angles, origins, CORDIC and multipliers
  ccd_dp #(.NUM_JOINTS(NUM_JOINTS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .target_x_i    (target_x_i),
    .target_y_i    (target_y_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .joint_angle_o (joint_angle_o),
    .tip_x_o       (tip_x_o),
    .tip_y_o       (tip_y_o),
    .near_target_o (near_target_o),
    .grip_phase_o  (grip_phase_o)
  );

  // result index is the sequencer's joint counter during the drain
  assign joint_index_o = cmd.jnt;

  // a new request is never taken while results are pending
  `CCD_ASSERT_NOW(a_no_overlap, clk_i, rst_ni, out_valid_o, !in_ready_o, "ready while draining")
  // last flag only on the final joint
  `CCD_ASSERT_NOW(a_last_idx, clk_i, rst_ni, out_valid_o && is_last_o, joint_index_o == IDX_LAST, "bad last")
  // taking the last result returns the block to idle
  `CCD_ASSERT_NEXT(a_back_idle, clk_i, rst_ni, out_valid_o && out_ready_i && is_last_o, in_ready_o && !out_valid_o, "not idle")

endmodule
